FILE: rtl/pds_pkg.sv
// Package for the distance PID and steering block: payload structs and register indexes.
package pds_pkg;

    typedef struct packed {
        logic [11:0] distance_mm;
        logic [9:0]  line_position;
        logic [2:0]  robot_mode;
    } t_in;

    typedef struct packed {
        logic               drive_valid;
        logic signed [15:0] right_speed;
        logic signed [15:0] left_speed;
    } t_out;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_DISTANCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SUM_ERROR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_GAIN         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_GAIN         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_THRESHOLD = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_GAIN      = 3'd7;

endpackage

FILE: rtl/pid_distance_steering.sv
// Distance PID regulator with deadband, integral clamp and line-following steering.
// An accepted input transaction is registered through stages 1 to 5; the stage 5 register drives the output.
// Throughput: one transaction per cycle while the output is not stalled; integral and last error update in stage 2.
// Each stage advances whenever the next one is empty or moving, so bubbles absorb output stall.
// Reset (i_rst_n low, synchronous): all stages empty, integral and last error zero,
// previous mode set to START_MODE, configuration registers back to their default values.
module pid_distance_steering
    import pds_pkg::*;
#(
    parameter int IMAGE_WIDTH = 640,
    parameter int CHASE_MODE  = 1,
    parameter int START_MODE  = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_data,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam logic [9:0] HALF_WIDTH = 10'(IMAGE_WIDTH / 2);
    localparam logic [2:0] CHASE_CODE = 3'(CHASE_MODE);
    localparam logic [2:0] START_CODE = 3'(START_MODE);

    // Clamp a wide signed value into the 16-bit motor range.
    function automatic logic signed [15:0] f_sat16(input logic signed [27:0] v);
        logic signed [15:0] res;
        if (v > 28'sd32767) begin
            res = 16'sh7fff;
        end else if (v < -28'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    // Q8.8 to integer: divide by 256 truncating toward zero, then saturate.
    function automatic logic signed [15:0] f_q88(input logic signed [35:0] v);
        logic signed [35:0] biased;
        logic signed [27:0] q;
        biased = v + (v[35] ? 36'sd255 : 36'sd0);
        q      = 28'(biased >>> 8);
        return f_sat16(q);
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        [11:0] r_goal;
    logic        [11:0] r_err_thr;
    logic        [15:0] r_max_sum;
    logic signed [15:0] r_kp;
    logic signed [15:0] r_ki;
    logic signed [15:0] r_kd;
    logic        [9:0]  r_steer_thr;
    logic signed [15:0] r_steer_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal       <= 12'd100;
            r_err_thr    <= 12'd2;
            r_max_sum    <= 16'd1000;
            r_kp         <= 16'sd256;
            r_ki         <= 16'sd0;
            r_kd         <= 16'sd0;
            r_steer_thr  <= 10'd10;
            r_steer_gain <= 16'sd512;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GOAL_DISTANCE:   r_goal       <= i_cfg_data[11:0];
                CFG_ERROR_THRESHOLD: r_err_thr    <= i_cfg_data[11:0];
                CFG_MAX_SUM_ERROR:   r_max_sum    <= i_cfg_data;
                CFG_KP_GAIN:         r_kp         <= i_cfg_data;
                CFG_KI_GAIN:         r_ki         <= i_cfg_data;
                CFG_KD_GAIN:         r_kd         <= i_cfg_data;
                CFG_STEER_THRESHOLD: r_steer_thr  <= i_cfg_data[9:0];
                CFG_STEER_GAIN:      r_steer_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage moves when the next is empty or moving
    // ------------------------------------------------------------------
    logic r1_v, r2_v, r3_v, r4_v, r5_v;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !r5_v || !i_out_stall;
    assign rdy4 = !r4_v || rdy5;
    assign rdy3 = !r3_v || rdy4;
    assign rdy2 = !r2_v || rdy3;
    assign rdy1 = !r1_v || rdy2;

    assign o_in_stall = !rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            if (rdy1) r1_v <= i_in_valid;
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
            if (rdy4) r4_v <= r3_v;
            if (rdy5) r5_v <= r4_v;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    t_in r1_in;

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_in_valid) begin
            r1_in <= i_in_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: error, derivative, deadband, integral update, steering offset.
    // The regulator state commits here, once per transaction.
    // ------------------------------------------------------------------
    logic signed [17:0] r_sum;
    logic signed [12:0] r_perr;
    logic        [2:0]  r_prev_mode;

    logic               mode_chg;
    logic               is_chase;
    logic signed [17:0] sum_base;
    logic signed [12:0] perr_base;
    logic signed [12:0] err;
    logic signed [13:0] deriv;
    logic signed [12:0] err_mag;
    logic               in_dead;
    logic signed [17:0] sum_add;
    logic signed [17:0] lim_pos;
    logic signed [17:0] lim_neg;
    logic signed [17:0] sum_clamp;
    logic signed [17:0] n_sum;
    logic signed [12:0] n_perr;
    logic signed [10:0] offs_raw;
    logic signed [10:0] offs_mag;
    logic signed [10:0] offs;
    logic               adv2;

    always_comb begin
        mode_chg  = (r1_in.robot_mode != r_prev_mode);
        is_chase  = (r1_in.robot_mode == CHASE_CODE);
        sum_base  = mode_chg ? 18'sd0 : r_sum;
        perr_base = mode_chg ? 13'sd0 : r_perr;

        err     = $signed({1'b0, r1_in.distance_mm}) - $signed({1'b0, r_goal});
        deriv   = 14'(err) - 14'(perr_base);
        err_mag = err[12] ? -err : err;
        in_dead = $unsigned(err_mag) < {1'b0, r_err_thr};

        // accumulate, then clamp to +-max
        sum_add = sum_base + 18'(err);
        lim_pos = $signed({2'b00, r_max_sum});
        lim_neg = -lim_pos;
        if (sum_add > lim_pos) begin
            sum_clamp = lim_pos;
        end else if (sum_add < lim_neg) begin
            sum_clamp = lim_neg;
        end else begin
            sum_clamp = sum_add;
        end

        n_sum  = (is_chase && !in_dead) ? sum_clamp : sum_base;
        n_perr = is_chase ? err : perr_base;

        // steering offset around the image center, zeroed inside its threshold
        offs_raw = $signed({1'b0, r1_in.line_position}) - $signed({1'b0, HALF_WIDTH});
        offs_mag = offs_raw[10] ? -offs_raw : offs_raw;
        offs     = ($unsigned(offs_mag) < {1'b0, r_steer_thr}) ? 11'sd0 : offs_raw;
    end

    assign adv2 = r1_v && rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= 18'sd0;
            r_perr      <= 13'sd0;
            r_prev_mode <= START_CODE;
        end else if (adv2) begin
            r_sum       <= n_sum;
            r_perr      <= n_perr;
            r_prev_mode <= r1_in.robot_mode;
        end
    end

    logic               r2_chase;
    logic               r2_dead;
    logic signed [12:0] r2_err;
    logic signed [17:0] r2_sum;
    logic signed [13:0] r2_deriv;
    logic signed [10:0] r2_offs;

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r2_chase <= is_chase;
            r2_dead  <= in_dead;
            r2_err   <= err;
            r2_sum   <= sum_clamp;
            r2_deriv <= deriv;
            r2_offs  <= offs;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: the four gain products, each registered
    // ------------------------------------------------------------------
    logic               r3_chase;
    logic               r3_dead;
    logic signed [28:0] r3_pp;
    logic signed [33:0] r3_pi;
    logic signed [29:0] r3_pd;
    logic signed [26:0] r3_ps;

    always_ff @(posedge i_clk) begin
        if (r2_v && rdy3) begin
            r3_chase <= r2_chase;
            r3_dead  <= r2_dead;
            r3_pp    <= 29'(r_kp) * 29'(r2_err);
            r3_pi    <= 34'(r_ki) * 34'(r2_sum);
            r3_pd    <= 30'(r_kd) * 30'(r2_deriv);
            r3_ps    <= 27'(r_steer_gain) * 27'(r2_offs);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: sum the PID terms, scale both Q8.8 values back to integers
    // ------------------------------------------------------------------
    logic signed [35:0] pid_total;
    logic               r4_chase;
    logic signed [15:0] r4_speed;
    logic signed [15:0] r4_corr;

    assign pid_total = 36'(r3_pp) + 36'(r3_pi) + 36'(r3_pd);

    always_ff @(posedge i_clk) begin
        if (r3_v && rdy4) begin
            r4_chase <= r3_chase;
            r4_speed <= r3_dead ? 16'sd0 : f_q88(pid_total);
            r4_corr  <= f_q88(36'(r3_ps));
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: apply steering to each motor, saturate, hold for the consumer
    // ------------------------------------------------------------------
    logic signed [16:0] left_sum;
    logic signed [16:0] right_sum;
    t_out               r5_out;

    assign left_sum  = 17'(r4_speed) + 17'(r4_corr);
    assign right_sum = 17'(r4_speed) - 17'(r4_corr);

    always_ff @(posedge i_clk) begin
        if (r4_v && rdy5) begin
            r5_out.drive_valid <= r4_chase;
            r5_out.left_speed  <= r4_chase ? f_sat16(28'(left_sum))  : 16'sd0;
            r5_out.right_speed <= r4_chase ? f_sat16(28'(right_sum)) : 16'sd0;
        end
    end

    assign o_out_valid = r5_v;
    assign o_out_data  = r5_out;

`ifndef SYNTH
    // Outside chase mode both motor fields must be zero.
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.drive_valid) |->
            (o_out_data.left_speed == 16'sd0 && o_out_data.right_speed == 16'sd0))
        else $error("nonzero speed outside chase mode");

    // Leaving for a non-chase mode clears the integral and the last error.
    a_mode_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv2 && mode_chg && !is_chase) |=> (r_sum == 18'sd0 && r_perr == 13'sd0))
        else $error("regulator state not cleared on mode change");

    // Input stall only when stage 1 holds a transaction that cannot move.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r1_v && r2_v && r3_v && r4_v && r5_v && i_out_stall))
        else $error("input stalled with room in the pipeline");

    // Reset leaves no result pending and a cleared integral.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && r_sum == 18'sd0 && r_perr == 13'sd0))
        else $error("state not cleared by reset");
`endif

endmodule
